// ===== src/sky_angle_to_ring_pixel_macros.svh =====
// Assertion macros shared by the sky angle to ring pixel RTL.
`ifndef SKY_ANGLE_TO_RING_PIXEL_MACROS_SVH
`define SKY_ANGLE_TO_RING_PIXEL_MACROS_SVH

`define SARP_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

`define SARP_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`define SARP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sarp_pkg.sv =====
// Shared types, constants and tables for the sky angle to ring pixel pipeline.
`default_nettype none
package sarp_pkg;

    localparam int RES_BITS = 14;
    localparam logic [RES_BITS-1:0] MAX_RESOLUTION = 14'd8192;
    localparam int ANGLE_BITS = 32;
    localparam int TERMS = 13;

    localparam logic [31:0] PI60_LO = 32'h885A308D;
    localparam logic [29:0] PI60_HI = 30'h3243F6A8;
    localparam logic [63:0] ONE60 = 64'h1000_0000_0000_0000;
    localparam logic [32:0] TWO_THIRDS_Q32 = 33'd2863311530;

    // Divisor (2k-1)(2k) of each Taylor term and floor(2^64 / divisor).
    localparam logic [9:0] TERM_DIV [TERMS] = '{
        10'd2, 10'd12, 10'd30, 10'd56, 10'd90, 10'd132, 10'd182,
        10'd240, 10'd306, 10'd380, 10'd462, 10'd552, 10'd650
    };

    localparam logic [63:0] TERM_RECIP [TERMS] = '{
        64'((65'd1 << 64) / 65'd2),   64'((65'd1 << 64) / 65'd12),
        64'((65'd1 << 64) / 65'd30),  64'((65'd1 << 64) / 65'd56),
        64'((65'd1 << 64) / 65'd90),  64'((65'd1 << 64) / 65'd132),
        64'((65'd1 << 64) / 65'd182), 64'((65'd1 << 64) / 65'd240),
        64'((65'd1 << 64) / 65'd306), 64'((65'd1 << 64) / 65'd380),
        64'((65'd1 << 64) / 65'd462), 64'((65'd1 << 64) / 65'd552),
        64'((65'd1 << 64) / 65'd650)
    };

    typedef struct packed {
        logic                south;
        logic [31:0]         azimuth;
        logic [RES_BITS-1:0] n;
    } ctx_t;

endpackage
`default_nettype wire

// ===== src/sarp_mul64.sv =====
// Two-stage 64 by 64 bit multiplier built from four 32 by 32 bit partial products.
`default_nettype none
module sarp_mul64 (
    input  logic         aclk,
    input  logic         ce,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] product
);
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] product_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p00_reg <= a[31:0] * b[31:0];
            p01_reg <= a[31:0] * b[63:32];
            p10_reg <= a[63:32] * b[31:0];
            p11_reg <= a[63:32] * b[63:32];
            product_reg <= {p11_reg, p00_reg} + {32'd0, p01_reg, 32'd0}
                         + {32'd0, p10_reg, 32'd0};
        end
    end

    assign product = product_reg;
endmodule
`default_nettype wire

// ===== src/sarp_term.sv =====
// One pipelined Taylor term of the cosine: multiply, exact division by a constant, accumulate.
`default_nettype none
module sarp_term (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic [3:0]        term_idx,
    input  logic              in_valid,
    input  sarp_pkg::ctx_t    in_ctx,
    input  logic [63:0]       in_x2,
    input  logic [63:0]       in_term,
    input  logic [63:0]       in_sum,
    output logic              out_valid,
    output sarp_pkg::ctx_t    out_ctx,
    output logic [63:0]       out_x2,
    output logic [63:0]       out_term,
    output logic [63:0]       out_sum
);
    import sarp_pkg::*;

    logic [127:0] prod1, prod2;
    logic [63:0]  p_val, q0, q;
    logic [9:0]   div;
    logic [11:0]  r12;

    logic         valid_reg [4];
    ctx_t         ctx_reg   [4];
    logic [63:0]  x2_reg    [4];
    logic [63:0]  sum_reg   [4];
    logic [63:0]  p_reg     [2];

    logic         out_valid_reg;
    ctx_t         out_ctx_reg;
    logic [63:0]  out_x2_reg, out_term_reg, out_sum_reg;

    sarp_mul64 u_prod (.aclk(aclk), .ce(ce), .a(in_term), .b(in_x2), .product(prod1));

    assign p_val = prod1[123:60];

    sarp_mul64 u_quot (.aclk(aclk), .ce(ce), .a(p_val), .b(TERM_RECIP[term_idx]),
                       .product(prod2));

    assign div = TERM_DIV[term_idx];
    assign q0  = prod2[127:64];
    assign r12 = p_reg[1][11:0] - 12'(q0[11:0] * {2'd0, div});
    assign q   = q0 + 64'(r12 >= {2'd0, div});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                valid_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < 4; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
            out_valid_reg <= valid_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctx_reg[0] <= in_ctx;
            x2_reg[0]  <= in_x2;
            sum_reg[0] <= in_sum;
            for (int i = 1; i < 4; i++) begin
                ctx_reg[i] <= ctx_reg[i-1];
                x2_reg[i]  <= x2_reg[i-1];
                sum_reg[i] <= sum_reg[i-1];
            end
            p_reg[0] <= p_val;
            p_reg[1] <= p_reg[0];
            out_ctx_reg  <= ctx_reg[3];
            out_x2_reg   <= x2_reg[3];
            out_term_reg <= q;
            // Odd-numbered terms of the series (even term_idx) are subtracted.
            out_sum_reg  <= term_idx[0] ? (sum_reg[3] + q) : (sum_reg[3] - q);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ctx   = out_ctx_reg;
    assign out_x2    = out_x2_reg;
    assign out_term  = out_term_reg;
    assign out_sum   = out_sum_reg;
endmodule
`default_nettype wire

// ===== src/sarp_isqrt.sv =====
// Fully pipelined 64-bit integer square root, one result bit per stage.
`default_nettype none
module sarp_isqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [63:0]       in_rad,
    input  logic [32:0]       in_za,
    input  sarp_pkg::ctx_t    in_ctx,
    output logic              out_valid,
    output logic [31:0]       out_root,
    output logic [32:0]       out_za,
    output sarp_pkg::ctx_t    out_ctx
);
    import sarp_pkg::*;

    localparam int STEPS = 32;

    logic         valid_reg [STEPS+1];
    logic [63:0]  rem_reg   [STEPS+1];
    logic [63:0]  root_reg  [STEPS+1];
    logic [32:0]  za_reg    [STEPS+1];
    ctx_t         ctx_reg   [STEPS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (ce) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0]  <= in_rad;
            root_reg[0] <= 64'd0;
            za_reg[0]   <= in_za;
            ctx_reg[0]  <= in_ctx;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] trial;
        logic        take;

        assign trial = root_reg[i] + BIT;
        assign take  = rem_reg[i] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (ce) begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[i+1]  <= take ? (rem_reg[i] - trial) : rem_reg[i];
                root_reg[i+1] <= take ? ((root_reg[i] >> 1) + BIT) : (root_reg[i] >> 1);
                za_reg[i+1]   <= za_reg[i];
                ctx_reg[i+1]  <= ctx_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign out_root  = root_reg[STEPS][31:0];
    assign out_za    = za_reg[STEPS];
    assign out_ctx   = ctx_reg[STEPS];
endmodule
`default_nettype wire

// ===== src/sarp_ring.sv =====
// Ring and in-ring position for the equatorial band and both polar caps, five stages.
`default_nettype none
module sarp_ring (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [32:0]       in_za,
    input  logic [31:0]       in_root,
    input  sarp_pkg::ctx_t    in_ctx,
    output logic              out_valid,
    output logic [29:0]       out_pixel
);
    import sarp_pkg::*;

    logic [4:0] valid_reg;
    ctx_t       ctx1_reg, ctx2_reg, ctx3_reg, ctx4_reg;
    logic       band1_reg, band2_reg, band3_reg, band4_reg;

    // Stage 1
    logic [33:0] tt;
    logic [51:0] p1_reg, q1_reg;
    logic [45:0] tmp1_reg;
    logic [27:0] nn1_reg;

    assign tt = {in_ctx.azimuth, 2'b00};

    // Stage 2
    logic [51:0] lo_sum, hi_sum;
    logic [17:0] lo, hi, jp, jm;
    logic signed [20:0] ir_raw, ir_max;
    logic [17:0] bjp2_reg, bjm2_reg;
    logic [14:0] bir2_reg;
    logic [31:0] tp;
    logic [63:0] pl2_reg;
    logic [45:0] ph2_reg, tmp2_reg;
    logic [27:0] nn2_reg;

    assign tp     = {ctx1_reg.azimuth[29:0], 2'b00};
    assign lo_sum = p1_reg - q1_reg;
    assign hi_sum = p1_reg + q1_reg;
    assign lo     = lo_sum[51:34];
    assign hi     = hi_sum[51:34];
    assign jp     = ctx1_reg.south ? hi : lo;
    assign jm     = ctx1_reg.south ? lo : hi;
    assign ir_raw = $signed({7'd0, ctx1_reg.n}) + 21'sd1 + $signed({3'd0, jp})
                  - $signed({3'd0, jm});
    assign ir_max = $signed({6'd0, ctx1_reg.n, 1'b1});

    // Stage 3
    logic signed [20:0] s_raw;
    logic [18:0] half;
    logic [15:0] four_n3;
    logic [15:0] bip3_reg;
    logic [14:0] bir3_reg;
    logic [77:0] a_prod, cjm_full;
    logic [13:0] cjp3_reg, cjm3_reg;
    logic [27:0] nn3_reg;

    assign s_raw   = $signed({3'd0, bjp2_reg}) + $signed({3'd0, bjm2_reg})
                   - $signed({7'd0, ctx2_reg.n}) + $signed({20'd0, ~bir2_reg[0]}) + 21'sd1;
    assign half    = s_raw[20] ? 19'd0 : s_raw[19:1];
    assign four_n3 = {ctx2_reg.n, 2'b00};
    assign a_prod  = {14'd0, pl2_reg} + {ph2_reg, 32'd0};
    assign cjm_full = {tmp2_reg, 32'd0} - a_prod;

    // Stage 4
    logic [14:0] cir;
    logic [48:0] tt_ir;
    logic [30:0] t4_reg, ncap4_reg, npix4_reg, cn4_reg, cs4_reg;
    logic [15:0] bip4_reg;
    logic [16:0] cip4_reg;
    logic [14:0] cir4_reg;
    logic [15:0] four_n4;

    assign cir     = 15'(cjp3_reg) + 15'(cjm3_reg) + 15'd1;
    assign tt_ir   = {ctx3_reg.azimuth, 2'b00} * cir;
    assign four_n4 = {ctx3_reg.n, 2'b00};

    // Stage 5
    logic [16:0] four_ir;
    logic [16:0] cip;
    logic [31:0] band_idx, cap_idx;
    logic [29:0] pixel_reg;

    assign four_ir  = {cir4_reg, 2'b00};
    assign cip      = (cip4_reg >= four_ir) ? (cip4_reg - four_ir) : cip4_reg;
    assign band_idx = 32'(ncap4_reg) + 32'(t4_reg) + 32'(bip4_reg);
    assign cap_idx  = ctx4_reg.south ? (32'(npix4_reg) - 32'(cs4_reg) + 32'(cip))
                                     : (32'(cn4_reg) + 32'(cip));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 5'd0;
        end else if (ce) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctx1_reg  <= in_ctx;
            band1_reg <= in_za <= TWO_THIRDS_Q32;
            p1_reg    <= 52'({in_ctx.n, 2'b00} * (35'd2147483648 + 35'(tt)));
            q1_reg    <= 52'((16'(in_ctx.n) * 16'd3) * in_za);
            tmp1_reg  <= 46'(in_ctx.n * in_root);
            nn1_reg   <= 28'(in_ctx.n * in_ctx.n);

            ctx2_reg  <= ctx1_reg;
            band2_reg <= band1_reg;
            bjp2_reg  <= jp;
            bjm2_reg  <= jm;
            if (ir_raw < 21'sd1) begin
                bir2_reg <= 15'd1;
            end else if (ir_raw > ir_max) begin
                bir2_reg <= ir_max[14:0];
            end else begin
                bir2_reg <= ir_raw[14:0];
            end
            pl2_reg   <= tp * tmp1_reg[31:0];
            ph2_reg   <= 46'(tp * tmp1_reg[45:32]);
            tmp2_reg  <= tmp1_reg;
            nn2_reg   <= nn1_reg;

            ctx3_reg  <= ctx2_reg;
            band3_reg <= band2_reg;
            bip3_reg  <= (half >= 19'(four_n3)) ? 16'(half - 19'(four_n3)) : 16'(half);
            bir3_reg  <= bir2_reg;
            cjp3_reg  <= a_prod[77:64];
            cjm3_reg  <= cjm_full[77:64];
            nn3_reg   <= nn2_reg;

            ctx4_reg  <= ctx3_reg;
            band4_reg <= band3_reg;
            t4_reg    <= 31'(four_n4 * (bir3_reg - 15'd1));
            ncap4_reg <= 31'({nn3_reg - 28'(ctx3_reg.n), 1'b0});
            npix4_reg <= 31'(nn3_reg * 5'd12);
            bip4_reg  <= bip3_reg;
            cip4_reg  <= tt_ir[48:32];
            cir4_reg  <= cir;
            cn4_reg   <= {30'(cir) * 30'(cir - 15'd1), 1'b0};
            cs4_reg   <= {30'(cir) * 30'(cir + 15'd1), 1'b0};

            pixel_reg <= band4_reg ? band_idx[29:0] : cap_idx[29:0];
        end
    end

    assign out_valid = valid_reg[4];
    assign out_pixel = pixel_reg;
endmodule
`default_nettype wire

// ===== src/sky_angle_to_ring_pixel.sv =====
// Throughput: one word per cycle while the output buffer has room; every stage of the
// cosine series, square root and ring arithmetic is registered, so the pipeline takes
// a new word in every cycle unless a full output buffer stalls it.
// A two-word output buffer lets the input keep flowing while a result waits.
// Reset (aresetn low, synchronous) empties the pipeline and sets the resolution to 1.
// Top level: input folding, cosine series chain, square root, ring math and output buffer.
`default_nettype none
module sky_angle_to_ring_pixel (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [13:0] cfg_data,      // resolution
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // [31:0] polar_angle, [63:32] azimuth
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // [29:0] pixel_index, [31:30] zero
);
    import sarp_pkg::*;
    `include "sky_angle_to_ring_pixel_macros.svh"

    logic ce;

    logic [RES_BITS-1:0] res_reg, n_eff;
    logic [31:0] polar, v_in;
    logic        south_in;

    logic        f1_valid_reg, f2_valid_reg, f3_valid_reg;
    ctx_t        f1_ctx_reg, f2_ctx_reg, f3_ctx_reg;
    logic [31:0] f1_v_reg;
    logic [63:0] f2_pl_reg;
    logic [61:0] f2_ph_reg;
    logic [63:0] f3_x_reg;

    logic [127:0] x_sq;
    logic         xd_valid_reg [2];
    ctx_t         xd_ctx_reg   [2];

    logic        ch_valid [TERMS+1];
    ctx_t        ch_ctx   [TERMS+1];
    logic [63:0] ch_x2    [TERMS+1];
    logic [63:0] ch_term  [TERMS+1];
    logic [63:0] ch_sum   [TERMS+1];

    logic [63:0] cos_val;
    logic        z_valid_reg, r_valid_reg;
    logic [32:0] z_za_reg, r_za_reg;
    ctx_t        z_ctx_reg, r_ctx_reg;
    logic [63:0] r_rad_reg;
    logic [33:0] one_minus, three_x;

    logic        sq_valid;
    logic [31:0] sq_root;
    logic [32:0] sq_za;
    ctx_t        sq_ctx;

    logic        ring_valid;
    logic [29:0] ring_pixel;

    logic [29:0] buf_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= 14'd1;
        end else if (cfg_valid) begin
            res_reg <= cfg_data;
        end
    end

    assign ce       = count_reg < 2'd2;
    assign s_tready = ce;

    assign polar    = s_tdata[31:0];
    assign south_in = polar > 32'h8000_0000;
    assign v_in     = south_in ? (~polar + 32'd1) : polar;
    assign n_eff    = (res_reg == '0) ? 14'd1
                    : ((res_reg > MAX_RESOLUTION) ? MAX_RESOLUTION : res_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            xd_valid_reg[0] <= 1'b0;
            xd_valid_reg[1] <= 1'b0;
            z_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end else if (ce) begin
            f1_valid_reg <= s_tvalid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            xd_valid_reg[0] <= f3_valid_reg;
            xd_valid_reg[1] <= xd_valid_reg[0];
            z_valid_reg <= ch_valid[TERMS];
            r_valid_reg <= z_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f1_ctx_reg <= '{south: south_in, azimuth: s_tdata[63:32], n: n_eff};
            f1_v_reg   <= v_in;
            f2_ctx_reg <= f1_ctx_reg;
            f2_pl_reg  <= f1_v_reg * PI60_LO;
            f2_ph_reg  <= f1_v_reg * PI60_HI;
            f3_ctx_reg <= f2_ctx_reg;
            f3_x_reg   <= 64'(f2_ph_reg) + 64'(f2_pl_reg[63:32]);
            xd_ctx_reg[0] <= f3_ctx_reg;
            xd_ctx_reg[1] <= xd_ctx_reg[0];
        end
    end

    sarp_mul64 u_xsq (.aclk(aclk), .ce(ce), .a(f3_x_reg), .b(f3_x_reg), .product(x_sq));

    assign ch_valid[0] = xd_valid_reg[1];
    assign ch_ctx[0]   = xd_ctx_reg[1];
    assign ch_x2[0]    = x_sq[123:60];
    assign ch_term[0]  = ONE60;
    assign ch_sum[0]   = ONE60;

    for (genvar k = 0; k < TERMS; k++) begin : g_term
        sarp_term u_term (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ce       (ce),
            .term_idx (4'(k)),
            .in_valid (ch_valid[k]),
            .in_ctx   (ch_ctx[k]),
            .in_x2    (ch_x2[k]),
            .in_term  (ch_term[k]),
            .in_sum   (ch_sum[k]),
            .out_valid(ch_valid[k+1]),
            .out_ctx  (ch_ctx[k+1]),
            .out_x2   (ch_x2[k+1]),
            .out_term (ch_term[k+1]),
            .out_sum  (ch_sum[k+1])
        );
    end

    assign cos_val = ch_sum[TERMS][63] ? 64'd0
                   : ((ch_sum[TERMS] > ONE60) ? ONE60 : ch_sum[TERMS]);
    assign one_minus = 34'h1_0000_0000 - {1'b0, z_za_reg};
    assign three_x   = 34'(one_minus * 2'd3);

    always_ff @(posedge aclk) begin
        if (ce) begin
            z_za_reg  <= cos_val[60:28];
            z_ctx_reg <= ch_ctx[TERMS];
            r_za_reg  <= z_za_reg;
            r_ctx_reg <= z_ctx_reg;
            r_rad_reg <= {three_x[31:0], 32'd0};
        end
    end

    sarp_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (r_valid_reg),
        .in_rad   (r_rad_reg),
        .in_za    (r_za_reg),
        .in_ctx   (r_ctx_reg),
        .out_valid(sq_valid),
        .out_root (sq_root),
        .out_za   (sq_za),
        .out_ctx  (sq_ctx)
    );

    sarp_ring u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (sq_valid),
        .in_za    (sq_za),
        .in_root  (sq_root),
        .in_ctx   (sq_ctx),
        .out_valid(ring_valid),
        .out_pixel(ring_pixel)
    );

    assign push = ce && ring_valid;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= ring_pixel;
        end
    end

    assign m_tvalid = count_reg != 2'd0;
    assign m_tdata  = {2'b00, buf_reg[rd_ptr_reg]};

    `SARP_ASSERT_ALWAYS(a_buf_bound, aclk, aresetn, count_reg <= 2'd2, "output buffer overfilled")
    `SARP_ASSERT_IMPLY(a_res_range, aclk, aresetn, f1_valid_reg, (f1_ctx_reg.n >= 14'd1) && (f1_ctx_reg.n <= MAX_RESOLUTION), "resolution out of range in pipeline")
    `SARP_ASSERT_NEXT(a_stall_hold, aclk, aresetn, !ce, $stable(f1_valid_reg) && $stable(z_valid_reg), "pipeline moved during stall")
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the sky angle to ring pixel block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import sarp_pkg::*;

    localparam int LATENCY = 110;
    localparam int LIMIT = 400000;
    localparam logic [63:0] PI60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] HALF_ANGLE = 64'h8000_0000;

    typedef struct {
        logic [31:0] polar;
        logic [31:0] azim;
        logic        known;
        logic [29:0] pixel;
    } row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [13:0] cfg_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;

    logic [13:0] resolution_now;
    logic [29:0] pixel_queue [$];
    int          errors = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          cycles = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    logic        recv_hold = 0;

    sky_angle_to_ring_pixel DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return 64'(p >> s);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] cosine_q60(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2 = mul_shift(x, x, 60);
        term = ONE60;
        sum = ONE60;
        for (int k = 1; k <= TERMS; k++) begin
            term = mul_shift(term, x2, 60) / 64'((2 * k - 1) * (2 * k));
            if (k & 1) sum -= term;
            else sum += term;
        end
        if (sum[63]) return 0;
        if (sum > ONE60) return ONE60;
        return sum;
    endfunction

    function automatic logic [29:0] ring_pixel(logic [31:0] polar, logic [31:0] azim,
                                               logic [13:0] res);
        longint n, ncap, npix, ir, ip, jp, jm, kshift, lo, hi;
        logic [63:0] v, za, tt, p, q, tp, r, tmp, pix;
        logic south;
        n = res;
        if (n < 1) n = 1;
        if (n > 8192) n = 8192;
        south = 64'(polar) > HALF_ANGLE;
        v = south ? (64'h1_0000_0000 - 64'(polar)) : 64'(polar);
        ncap = 2 * n * (n - 1);
        npix = 12 * n * n;
        za = cosine_q60(mul_shift(v, PI60, 32)) >> 28;
        tt = 64'(azim) << 2;
        if (za <= 64'(TWO_THIRDS_Q32)) begin
            p = 64'(4 * n) * ((64'd1 << 31) + tt);
            q = 64'(3 * n) * za;
            lo = longint'((p - q) >> 34);
            hi = longint'((p + q) >> 34);
            jp = south ? hi : lo;
            jm = south ? lo : hi;
            ir = n + 1 + jp - jm;
            if (ir < 1) ir = 1;
            if (ir > 2 * n + 1) ir = 2 * n + 1;
            kshift = (ir & 1) ? 0 : 1;
            ip = jp + jm - n + kshift + 1;
            if (ip < 0) ip = 0;
            ip = (ip / 2) % (4 * n);
            pix = 64'(ncap + 4 * n * (ir - 1) + ip);
        end else begin
            tp = tt & 64'hFFFF_FFFF;
            r = root64((64'd3 * ((64'd1 << 32) - za)) << 32);
            tmp = 64'(n) * r;
            jp = longint'(mul_shift(tp, tmp, 64));
            jm = longint'(mul_shift((64'd1 << 32) - tp, tmp, 64));
            ir = jp + jm + 1;
            ip = longint'((tt * 64'(ir)) >> 32);
            if (ip >= 4 * ir) ip -= 4 * ir;
            if (!south) pix = 64'(2 * ir * (ir - 1) + ip);
            else pix = 64'(npix - 2 * ir * (ir + 1) + ip);
        end
        return pix[29:0];
    endfunction

    // Receiver: random stalls per rate, or a long hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (recv_hold) begin
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
        if (aresetn && m_tvalid && m_tready) begin
            words_out <= words_out + 1;
            if (pixel_queue.size() == 0) begin
                $display("%0t unexpected word: actual %0d", $time, m_tdata[29:0]);
                errors++;
            end else begin
                logic [29:0] want;
                want = pixel_queue.pop_front();
                if (m_tdata[29:0] !== want || m_tdata[31:30] !== 2'b00) begin
                    $display("%0t pixel_index mismatch: expected %0d actual %0d (raw %h)",
                             $time, want, m_tdata[29:0], m_tdata);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(logic [31:0] polar, logic [31:0] azim, logic known,
                             logic [29:0] pixel);
        logic [29:0] want;
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        want = ring_pixel(polar, azim, resolution_now);
        if (known && want !== pixel) begin
            $display("%0t table entry disagrees: expected %0d predicted %0d",
                     $time, pixel, want);
            errors++;
        end
        s_tvalid <= 1;
        s_tdata <= {azim, polar};
        do @(posedge aclk); while (!s_tready);
        pixel_queue.push_back(known ? pixel : want);
        words_in++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pixel_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic set_resolution(logic [13:0] value);
        drain();
        cfg_valid <= 1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        resolution_now = value;
    endtask

    task automatic random_words(int count);
        logic [31:0] polar;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(9);
            if (pick < 3) polar = $urandom_range(32'h1F00_0000);
            else if (pick < 6) polar = 32'hFFFF_FFFF - $urandom_range(32'h1F00_0000);
            else if (pick < 7) polar = 32'h8000_0000 + $urandom_range(8) - 4;
            else polar = $urandom;
            send_word(polar, $urandom, 0, '0);
        end
    endtask

    row_t directed [] = '{
        '{32'h0000_0000, 32'h0000_0000, 1, 30'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 30'd11},
        '{32'h8000_0000, 32'h0000_0000, 1, 30'd4},
        '{32'h8000_0001, 32'h0000_0000, 0, 30'd0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 0, 30'd0},
        '{32'h2000_0000, 32'h4000_0000, 0, 30'd0},
        '{32'hE000_0000, 32'hC000_0000, 0, 30'd0},
        '{32'h3000_0000, 32'h2000_0000, 0, 30'd0},
        '{32'hD000_0000, 32'h6000_0000, 0, 30'd0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 0, 30'd0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 0, 30'd0},
        '{32'h0000_0001, 32'h8000_0001, 0, 30'd0},
        '{32'h3AE1_47AE, 32'h1234_5678, 0, 30'd0},
        '{32'hC51E_B852, 32'hFEDC_BA98, 0, 30'd0}
    };

    logic [13:0] res_list [] = '{14'd1, 14'd0, 14'd16383, 14'd8192, 14'd2,
                                 14'd3, 14'd5000, 14'd64};

    initial begin
        resolution_now = 14'd1;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (directed[i])
            send_word(directed[i].polar, directed[i].azim, directed[i].known,
                      directed[i].pixel);
        foreach (res_list[i]) begin
            if (i != 0) set_resolution(res_list[i]);
            case (i % 3)
                0: begin send_idle = 21; recv_idle = 59; end
                1: begin send_idle = 59; recv_idle = 21; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            foreach (directed[j]) if (!directed[j].known || i == 0)
                send_word(directed[j].polar, directed[j].azim, 0, '0);
            random_words(25);
        end
        send_idle = 0;
        recv_idle = 0;
        fork
            begin
                recv_hold = 1;
                repeat (300) @(posedge aclk);
                recv_hold = 0;
            end
            random_words(130);
        join
        drain();
        $display("Covered %0d words in, %0d out, over %0d resolution settings.",
                 words_in, words_out, res_list.size());
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+src
src/sarp_pkg.sv
src/sarp_mul64.sv
src/sarp_term.sv
src/sarp_isqrt.sv
src/sarp_ring.sv
src/sky_angle_to_ring_pixel.sv
test/tb.sv
